@@ hw/rtl/cascaded_biquad_equalizer_assert.svh @@
// Assertion macros shared by the equalizer RTL.
// Assumes the including module has clk_i and the active-low reset rst_ni.
`ifndef CASCADED_BIQUAD_EQUALIZER_ASSERT_SVH
`define CASCADED_BIQUAD_EQUALIZER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define CBEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle that implies a result in the following cycle.
`define CBEQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define CBEQ_ASSERT(lbl, prop, msg)
`define CBEQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ hw/rtl/cbeq_pkg.sv @@
// Package for the cascaded biquad equalizer: sizes, codes, control struct
// and the 16-bit saturation function. No dependencies.
package cbeq_pkg;

  // Filter structure.
  localparam int BANDS      = 12;
  localparam int FRAC_BITS  = 15;
  localparam int NCOEF      = 5;
  localparam int COEF_DEPTH = BANDS * NCOEF;

  // Field widths.
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 32;
  localparam int ACC_W       = 32;
  localparam int PROD_W      = 2 * COEF_W;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  // Address widths for the band and coefficient stores.
  localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int CADDR_W = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

  // Saturation limits of a section output.
  localparam logic signed [ACC_W-1:0] SAT_MAX = 32'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -32'sd32768;

  // Input item kinds carried on tuser.
  typedef enum logic {
    FUNC_FILTER = 1'b0,
    FUNC_COEF   = 1'b1
  } cbeq_func_e;

  // Coefficient order within a band, also the product order of the MAC.
  typedef enum logic [2:0] {
    TERM_B0 = 3'd0,
    TERM_B1 = 3'd1,
    TERM_B2 = 3'd2,
    TERM_A1 = 3'd3,
    TERM_A2 = 3'd4
  } cbeq_term_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } cbeq_state_e;

  // Controls from the sequencer to the MAC unit.
  typedef struct packed {
    logic       mul_en;
    cbeq_term_e term_sel;
    logic       acc_clr;
    logic       writeback;
  } cbeq_mac_ctrl_t;

  // Clamp a 32-bit sum into the signed 16-bit sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/cbeq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cbeq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/cbeq_mac.sv @@
// Shared multiply-accumulate unit: one 32x32 multiplier, a Q15 floor shift,
// a wrapping accumulator and the running section sample. Uses cbeq_pkg.
module cbeq_mac import cbeq_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cbeq_mac_ctrl_t             ctrl_i,
  input  logic                       load_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [COEF_W-1:0]   coef_i,
  input  logic signed [SAMPLE_W-1:0] x1_i,
  input  logic signed [SAMPLE_W-1:0] x2_i,
  input  logic signed [ACC_W-1:0]    y1_i,
  input  logic signed [ACC_W-1:0]    y2_i,
  output logic signed [SAMPLE_W-1:0] x_cur_o,
  output logic signed [ACC_W-1:0]    acc_o
);

  logic signed [ACC_W-1:0]    op;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [PROD_W-1:0]   prod_sh;
  logic signed [ACC_W-1:0]    term;
  logic signed [ACC_W-1:0]    acc_d, acc_q;
  logic signed [SAMPLE_W-1:0] x_cur_d, x_cur_q;
  logic                       prod_v_q, sub_q;

  // Operand select for the current product.
  always_comb begin
    case (ctrl_i.term_sel)
      TERM_B0: op = {{(ACC_W-SAMPLE_W){x_cur_q[SAMPLE_W-1]}}, x_cur_q};
      TERM_B1: op = {{(ACC_W-SAMPLE_W){x1_i[SAMPLE_W-1]}}, x1_i};
      TERM_B2: op = {{(ACC_W-SAMPLE_W){x2_i[SAMPLE_W-1]}}, x2_i};
      TERM_A1: op = y1_i;
      TERM_A2: op = y2_i;
      default: op = '0;
    endcase
  end

  assign prod_d = coef_i * op;

  // Floor the registered product and keep its low 32 bits.
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign term    = prod_sh[ACC_W-1:0];

  // Feedback terms are subtracted; the sum wraps at 32 bits.
  always_comb begin
    if (!prod_v_q) begin
      acc_d = acc_q;
    end else if (sub_q) begin
      acc_d = acc_q - term;
    end else begin
      acc_d = acc_q + term;
    end
  end

  // Next section input: the fresh sample or the clamped section output.
  always_comb begin
    x_cur_d = x_cur_q;
    if (load_i) begin
      x_cur_d = sample_i;
    end else if (ctrl_i.writeback) begin
      x_cur_d = sat16(acc_d);
    end
  end

  // Product valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctrl_i.mul_en;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
      sub_q  <= (ctrl_i.term_sel == TERM_A1) || (ctrl_i.term_sel == TERM_A2);
    end
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
    x_cur_q <= x_cur_d;
  end

  assign x_cur_o = x_cur_q;
  assign acc_o   = acc_d;

endmodule

@@ hw/rtl/cbeq_seq.sv @@
// Sequencer of the equalizer: walks the bands and the five products of each
// band through the shared MAC unit. Uses cbeq_pkg and the assertion macros.
`include "cascaded_biquad_equalizer_assert.svh"
module cbeq_seq import cbeq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               out_free_i,
  output logic               idle_o,
  output logic [BAND_W-1:0]  band_o,
  output logic [CADDR_W-1:0] coef_raddr_o,
  output cbeq_mac_ctrl_t     ctrl_o,
  output logic               out_load_o
);

  localparam logic [BAND_W-1:0]  LastBand = BAND_W'(BANDS - 1);
  localparam logic [CADDR_W-1:0] LastCoef = CADDR_W'(COEF_DEPTH - 1);

  cbeq_state_e        state_d, state_q;
  logic [BAND_W-1:0]  band_d, band_q;
  logic [CADDR_W-1:0] caddr_d, caddr_q;
  cbeq_term_e         k_d, k_q;
  logic               caddr_inc;

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      band_q  <= '0;
      caddr_q <= '0;
      k_q     <= TERM_B0;
    end else begin
      state_q <= state_d;
      band_q  <= band_d;
      caddr_q <= caddr_d;
      k_q     <= k_d;
    end
  end

  // Next state and controls.
  always_comb begin
    state_d    = state_q;
    band_d     = band_q;
    k_d        = k_q;
    caddr_inc  = 1'b0;
    ctrl_o     = '{mul_en: 1'b0, term_sel: k_q, acc_clr: 1'b0, writeback: 1'b0};
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          band_d  = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        ctrl_o.acc_clr = 1'b1;
        caddr_inc      = 1'b1;
        k_d            = TERM_B0;
        state_d        = ST_MAC;
      end
      ST_MAC: begin
        ctrl_o.mul_en = 1'b1;
        if (k_q == TERM_A2) begin
          state_d = ST_DRAIN;
        end else begin
          caddr_inc = 1'b1;
          k_d       = cbeq_term_e'(3'(k_q + 3'd1));
        end
      end
      ST_DRAIN: begin
        ctrl_o.writeback = 1'b1;
        if (band_q == LastBand) begin
          state_d = ST_DONE;
        end else begin
          band_d  = band_q + BAND_W'(1);
          state_d = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Coefficients are read in store order, wrapping back to the first band.
  always_comb begin
    caddr_d = caddr_q;
    if (state_q == ST_IDLE && start_i) begin
      caddr_d = '0;
    end else if (caddr_inc) begin
      caddr_d = (caddr_q == LastCoef) ? '0 : caddr_q + CADDR_W'(1);
    end
  end

  assign idle_o       = (state_q == ST_IDLE);
  assign band_o       = band_q;
  assign coef_raddr_o = caddr_q;

  `CBEQ_ASSERT_NEXT(a_start_fetch, start_i && state_q == ST_IDLE, state_q == ST_FETCH && band_q == '0, "sample start did not begin at the first band")
  `CBEQ_ASSERT_NEXT(a_drain_next, state_q == ST_DRAIN && band_q != LastBand, state_q == ST_FETCH, "band write-back not followed by next band fetch")
  `CBEQ_ASSERT(a_drain_after_a2, state_q != ST_DRAIN || ($past(state_q) == ST_MAC && $past(k_q) == TERM_A2), "write-back without all five products")

endmodule

@@ hw/rtl/cascaded_biquad_equalizer.sv @@
// Top level of the cascaded biquad equalizer: stream ports, coefficient and
// history RAMs with their valid bits, sequencer and MAC. Uses cbeq_pkg and the assertion macros.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tuser=func, tlast=sample_last, tdata=fields
// m_axis    out  tvalid/tready          tlast=out_last, tdata=sample_out
//
// For each band a sample needs a fetch, five passes through the single shared
// multiplier and a write-back.
// A coefficient write leaves the sequencer idle, so the block stays ready.
// Reset empties all stores at once through valid bits; no clearing pass.
// The input is not ready while a sample is filtered; a new item is accepted
// while a finished result still waits in the output register.
`include "cascaded_biquad_equalizer_assert.svh"
module cascaded_biquad_equalizer import cbeq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: sample_in[15:0], band_index[19:16], coef_select[22:20],
  //        coef_value[54:23], zero [55]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func[0]
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: sample_out[15:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  // Input fields.
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [3:0]                 band_index;
  logic [2:0]                 coef_select;
  logic [COEF_W-1:0]          coef_value;
  cbeq_func_e                 func;

  logic               s_hs, start, coef_we, in_range;
  logic [BAND_W-1:0]  wband;
  logic [CADDR_W-1:0] coef_waddr;

  logic               seq_idle, out_free, out_load;
  logic [BAND_W-1:0]  seq_band;
  logic [CADDR_W-1:0] coef_raddr;
  cbeq_mac_ctrl_t     mac_ctrl;

  logic [COEF_DEPTH-1:0]   coef_valid_q;
  logic [BANDS-1:0]        hist_valid_q;
  logic                    coef_rv_q, hist_rv_q;
  logic [COEF_W-1:0]       coef_rdata;
  logic [2*SAMPLE_W-1:0]   xh_rdata, xh_wdata;
  logic [2*ACC_W-1:0]      yh_rdata, yh_wdata;

  logic signed [COEF_W-1:0]   coef_m;
  logic signed [SAMPLE_W-1:0] x1_m, x2_m, x_cur;
  logic signed [ACC_W-1:0]    y1_m, y2_m, acc;

  logic                   last_q;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_last_q;

  assign sample_in   = s_axis_tdata[15:0];
  assign band_index  = s_axis_tdata[19:16];
  assign coef_select = s_axis_tdata[22:20];
  assign coef_value  = s_axis_tdata[54:23];
  assign func        = cbeq_func_e'(s_axis_tuser);

  // Input transaction decode; writes outside the store are dropped.
  assign s_axis_tready = seq_idle;
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign in_range      = (32'(band_index) < BANDS) && (32'(coef_select) < NCOEF);
  assign start         = s_hs && (func == FUNC_FILTER);
  assign coef_we       = s_hs && (func == FUNC_COEF) && in_range;
  assign wband         = BAND_W'(band_index);
  assign coef_waddr    = CADDR_W'(32'(band_index) * NCOEF + 32'(coef_select));

  cbeq_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .out_free_i   (out_free),
    .idle_o       (seq_idle),
    .band_o       (seq_band),
    .coef_raddr_o (coef_raddr),
    .ctrl_o       (mac_ctrl),
    .out_load_o   (out_load)
  );

  // Coefficient store, one entry per band and coefficient.
  cbeq_ram #(.Width(COEF_W), .Depth(COEF_DEPTH)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_value),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Input history per band: x1 in the low half, x2 in the high half.
  cbeq_ram #(.Width(2*SAMPLE_W), .Depth(BANDS)) u_xhist_ram (
    .clk_i   (clk_i),
    .we_i    (mac_ctrl.writeback),
    .waddr_i (seq_band),
    .wdata_i (xh_wdata),
    .raddr_i (seq_band),
    .rdata_o (xh_rdata)
  );

  // Output history per band: y1 in the low half, y2 in the high half.
  cbeq_ram #(.Width(2*ACC_W), .Depth(BANDS)) u_yhist_ram (
    .clk_i   (clk_i),
    .we_i    (mac_ctrl.writeback),
    .waddr_i (seq_band),
    .wdata_i (yh_wdata),
    .raddr_i (seq_band),
    .rdata_o (yh_rdata)
  );

  // Valid bits: an entry never written reads as zero. A coefficient write
  // empties the history of its band.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_valid_q <= '0;
      hist_valid_q <= '0;
      coef_rv_q    <= 1'b0;
      hist_rv_q    <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_valid_q[coef_waddr] <= 1'b1;
        hist_valid_q[wband]      <= 1'b0;
      end else if (mac_ctrl.writeback) begin
        hist_valid_q[seq_band] <= 1'b1;
      end
      coef_rv_q <= coef_valid_q[coef_raddr];
      hist_rv_q <= hist_valid_q[seq_band];
    end
  end

  assign coef_m = coef_rv_q ? coef_rdata : '0;
  assign x1_m   = hist_rv_q ? xh_rdata[SAMPLE_W-1:0] : '0;
  assign x2_m   = hist_rv_q ? xh_rdata[2*SAMPLE_W-1:SAMPLE_W] : '0;
  assign y1_m   = hist_rv_q ? yh_rdata[ACC_W-1:0] : '0;
  assign y2_m   = hist_rv_q ? yh_rdata[2*ACC_W-1:ACC_W] : '0;

  // History shift on write-back; y keeps the unsaturated sum.
  assign xh_wdata = {x1_m, x_cur};
  assign yh_wdata = {y1_m, acc};

  cbeq_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .load_i   (start),
    .sample_i (sample_in),
    .coef_i   (coef_m),
    .x1_i     (x1_m),
    .x2_i     (x2_m),
    .y1_i     (y1_m),
    .y2_i     (y2_m),
    .x_cur_o  (x_cur),
    .acc_o    (acc)
  );

  // Last flag of the sample in flight.
  always_ff @(posedge clk_i) begin
    if (start) begin
      last_q <= s_axis_tlast;
    end
  end

  // Output register.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= x_cur;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `CBEQ_ASSERT(a_hist_band_range, !mac_ctrl.writeback || (32'(seq_band) < BANDS), "history write-back outside the band range")
  `CBEQ_ASSERT(a_coef_when_idle, !coef_we || seq_idle, "coefficient write while a sample is in flight")
  `CBEQ_ASSERT_NEXT(a_out_load, out_load, m_axis_tvalid && m_axis_tdata == $past(x_cur), "result not presented after load")

endmodule
